### rtl/core/tcc_pkg.sv
// Package for the text console cursor and scroll unit.
// Holds opcodes, character codes, state types and the sweep command struct.
// No dependencies.
package tcc_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] NULL_CHAR    = 8'h00;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  localparam int CELL_W = 16;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_WALK
  } top_state_t;

  typedef enum logic [2:0] {
    WK_IDLE,
    WK_ZERO,
    WK_SWEEP,
    WK_DRAIN,
    WK_BLANK
  } walk_state_t;

  typedef enum logic [1:0] {
    WALK_ZERO,
    WALK_CLEAR,
    WALK_SCROLL
  } walk_mode_t;

  typedef struct packed {
    logic       go;
    walk_mode_t mode;
    logic [7:0] color;
  } walk_cmd_t;

endpackage

### rtl/core/tcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tcc_walker.sv
// Store sweep engine: zero fill after reset, clear of character bytes,
// and scroll (row copy followed by blanking of the last row). Uses tcc_pkg.
module tcc_walker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tcc_pkg::walk_cmd_t              cmd,
  output logic                            done,
  output logic                            mem_we,
  output logic [$clog2(ROWS*COLS)-1:0]    mem_waddr,
  output logic [tcc_pkg::CELL_W-1:0]      mem_wdata,
  output logic [$clog2(ROWS*COLS)-1:0]    mem_raddr,
  input  logic [tcc_pkg::CELL_W-1:0]      mem_rdata
);
  import tcc_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int AW     = $clog2(CELLS);
  localparam int COPY_N = (ROWS - 1) * COLS;
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY  = AW'(COPY_N - 1);
  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [AW-1:0] BLANK_BASE = AW'(COPY_N);

  walk_state_t      state, state_next;
  walk_mode_t       mode;
  logic [7:0]       color;
  logic [AW-1:0]    cnt;
  logic             pend_valid;
  logic [AW-1:0]    pend_addr;
  logic [AW-1:0]    sweep_last;

  assign sweep_last = (mode == WALK_SCROLL) ? LAST_COPY : LAST_CELL;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      WK_IDLE: begin
        if (cmd.go) begin
          state_next = (cmd.mode == WALK_ZERO) ? WK_ZERO : WK_SWEEP;
        end
      end
      WK_ZERO: begin
        if (cnt == LAST_CELL) state_next = WK_IDLE;
      end
      WK_SWEEP: begin
        if (cnt == sweep_last) state_next = WK_DRAIN;
      end
      WK_DRAIN: begin
        state_next = (mode == WALK_SCROLL) ? WK_BLANK : WK_IDLE;
      end
      WK_BLANK: begin
        if (cnt == LAST_CELL) state_next = WK_IDLE;
      end
      default: state_next = WK_IDLE;
    endcase
  end

  // memory port and completion
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    mem_raddr = (mode == WALK_SCROLL) ? cnt + COLS_A : cnt;
    done      = 1'b0;
    if (pend_valid) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = (mode == WALK_CLEAR) ? {mem_rdata[15:8], SPACE_CHAR} : mem_rdata;
    end
    case (state)
      WK_ZERO: begin
        mem_we = 1'b1;
        done   = (cnt == LAST_CELL);
      end
      WK_DRAIN: begin
        done = (mode != WALK_SCROLL);
      end
      WK_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {color, SPACE_CHAR};
        done      = (cnt == LAST_CELL);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= WK_ZERO;
      mode       <= WALK_ZERO;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == WK_SWEEP);
      case (state)
        WK_IDLE: begin
          if (cmd.go) begin
            mode <= cmd.mode;
            cnt  <= '0;
          end
        end
        WK_DRAIN: cnt <= BLANK_BASE;
        default:  cnt <= cnt + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == WK_IDLE && cmd.go) begin
      color <= cmd.color;
    end
    pend_addr <= cnt;
  end

  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == WK_SWEEP || state == WK_DRAIN))
    else $error("pending write outside a sweep");

  a_drain_once: assert property (@(posedge clk) disable iff (rst)
    (state == WK_DRAIN) |=> (state == WK_IDLE || state == WK_BLANK))
    else $error("drain did not end the sweep");

  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == WK_IDLE))
    else $error("sweep engine kept running after done");

endmodule

### rtl/core/text_console_cursor_scroll_unit.sv
// Put, newline, null, unused opcode, out-of-range read: done in the cycle after accept.
// Read in range: done is registered from the read state (one registered RAM read).
// Clear, scroll by put or newline: done after a sweep, one cell per cycle through the store.
// Throughput: one at a time; a put every cycle unless it scrolls; busy through each read.
// Reset: synchronous; busy stays high while the store is zero filled.
// Results are strobed on done for one cycle; the receiver cannot stall.
module text_console_cursor_scroll_unit #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [10:0] cell_index,
  output logic        done,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_column,
  output logic [10:0] cursor_position,
  output logic [15:0] read_data
);
  import tcc_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  // wide enough for the cell index and for the cell count itself
  localparam int IW    = (AW + 1 > 11) ? AW + 1 : 11;

  top_state_t state, state_next;

  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     pos;
  logic [CW:0]       col_inc;
  logic              last_row;
  logic              col_wrap;
  logic              accept;
  logic              read_ok;

  // decoded actions of the accepted transaction
  logic              put_we;
  logic              emit_now;
  walk_cmd_t         walk_cmd;

  logic              walk_done;
  logic              walk_we;
  logic [AW-1:0]     walk_waddr;
  logic [CELL_W-1:0] walk_wdata;
  logic [AW-1:0]     walk_raddr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign pos      = AW'(row) * AW'(COLS) + AW'(col);
  assign col_inc  = {1'b0, col} + 1'b1;
  assign col_wrap = (col_inc == (CW + 1)'(COLS));
  assign last_row = (row == RW'(ROWS - 1));
  assign read_ok  = (IW'(cell_index) < IW'(CELLS));

  // Decode the transaction: a put may write a cell, a row change on the last row
  // hands the scroll to the sweep engine, and a clear starts a clear sweep.
  always_comb begin
    put_we         = 1'b0;
    emit_now       = 1'b0;
    walk_cmd.go    = 1'b0;
    walk_cmd.mode  = WALK_SCROLL;
    walk_cmd.color = color;
    if (accept) begin
      case (opcode)
        OP_PUT: begin
          if (char_code == NEWLINE_CHAR) begin
            walk_cmd.go = last_row;
          end else if (char_code != NULL_CHAR) begin
            put_we      = 1'b1;
            walk_cmd.go = col_wrap && last_row;
          end
          emit_now = !walk_cmd.go;
        end
        OP_CLEAR: begin
          walk_cmd.go   = 1'b1;
          walk_cmd.mode = WALK_CLEAR;
        end
        OP_READ: begin
          emit_now = !read_ok;
        end
        default: begin
          emit_now = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (walk_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (walk_cmd.go) begin
          state_next = ST_WALK;
        end else if (accept && opcode == OP_READ && read_ok) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_WALK: begin
        if (walk_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The sweep engine owns the write port outside idle; a put writes only in idle.
  assign ram_we    = walk_we || put_we;
  assign ram_waddr = walk_we ? walk_waddr : pos;
  assign ram_wdata = walk_we ? walk_wdata : {color, char_code};
  assign ram_raddr = (state == ST_IDLE) ? AW'(cell_index) : walk_raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      row   <= '0;
      col   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit_now || (state == ST_READ) || (state == ST_WALK && walk_done);
      if (accept) begin
        case (opcode)
          OP_PUT: begin
            // advance the cursor; on the last row the row holds and the store scrolls
            if (char_code == NEWLINE_CHAR || (char_code != NULL_CHAR && col_wrap)) begin
              col <= '0;
              if (!last_row) row <= row + 1'b1;
            end else if (char_code != NULL_CHAR) begin
              col <= col_inc[CW-1:0];
            end
          end
          OP_CLEAR: begin
            row <= '0;
            col <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // read data is zero for every transaction but an in-range read
  always_ff @(posedge clk) begin
    read_data <= (state == ST_READ) ? ram_rdata : '0;
  end

  assign cursor_row      = 5'(row);
  assign cursor_column   = 7'(col);
  assign cursor_position = 11'(pos);

  tcc_walker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cmd       (walk_cmd),
    .done      (walk_done),
    .mem_we    (walk_we),
    .mem_waddr (walk_waddr),
    .mem_wdata (walk_wdata),
    .mem_raddr (walk_raddr),
    .mem_rdata (ram_rdata)
  );

  tcc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(walk_we && put_we))
    else $error("cell write from both sweep and put");

  a_init_silent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |=> !done)
    else $error("result strobed during the reset fill");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (done && state == ST_IDLE))
    else $error("read did not complete in one cycle");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((int'(row) < ROWS) && (int'(col) < COLS)))
    else $error("cursor out of the screen");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_CLEAR) |=> (busy && !done))
    else $error("clear did not start a sweep");

endmodule

### sim/tb_text_console_cursor_scroll_unit.sv
`timescale 1ns / 1ps
// Testbench for text_console_cursor_scroll_unit: directed and random console traffic
// checked against a shadow screen and cursor kept in the bench. Depends on tcc_pkg.
module tb_text_console_cursor_scroll_unit;
  import tcc_pkg::*;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  // Opcode 3 has no meaning in the block; name it so stimulus stays readable.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Worst case: every item a full-store sweep plus the longest sender gap, plus the
  // zero fill after reset, then several times over.
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int DRAIN_CYCLES   = CELLS + 100;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  column;
    logic [10:0] position;
    logic [15:0] read_data;
  } cursor_report_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic [7:0]  color;
  logic [10:0] cell_index;
  logic        done;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_column;
  logic [10:0] cursor_position;
  logic [15:0] read_data;

  // Shadow copy of the screen store and cursor, advanced at each accepted transaction.
  logic [15:0]    shadow_cells [CELLS];
  logic [4:0]     shadow_row;
  logic [6:0]     shadow_col;

  // Cursor and read reports still owed by the block, oldest first.
  cursor_report_t cursor_report_q [$];
  cursor_report_t seen_report;
  cursor_report_t owed_report;

  int  failure_count;
  int  cycle_count;
  bit  gaps_enabled;

  text_console_cursor_scroll_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .char_code       (char_code),
    .color           (color),
    .cell_index      (cell_index),
    .done            (done),
    .cursor_row      (cursor_row),
    .cursor_column   (cursor_column),
    .cursor_position (cursor_position),
    .read_data       (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow console
  // ---------------------------------------------------------------------------

  // Shift every row up by one whole cell row and blank the last row in the color.
  task automatic scroll_shadow(input logic [7:0] fill_color);
    for (int i = 0; i < (ROWS - 1) * COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
    for (int i = (ROWS - 1) * COLS; i < CELLS; i++) shadow_cells[i] = {fill_color, SPACE_CHAR};
    shadow_row = 5'(ROWS - 1);
    shadow_col = '0;
  endtask

  // Move to column 0 of the next row; scroll if already on the last row.
  task automatic advance_row(input logic [7:0] fill_color);
    shadow_col = '0;
    if (int'(shadow_row) >= ROWS - 1) scroll_shadow(fill_color);
    else shadow_row = shadow_row + 5'd1;
  endtask

  // Apply one transaction to the shadow console and return the report it owes.
  task automatic apply_console_op(input logic [1:0] op, input logic [7:0] ch,
                                  input logic [7:0] attr, input logic [10:0] idx,
                                  output cursor_report_t rep);
    int          pos;
    logic [15:0] rdata;
    rdata = '0;
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          advance_row(attr);
        end else if (ch != NULL_CHAR) begin
          pos = int'(shadow_row) * COLS + int'(shadow_col);
          if (pos < CELLS) shadow_cells[pos] = {attr, ch};
          shadow_col = shadow_col + 7'd1;
          // Wrap past the last column goes down at once, scrolling if needed.
          if (int'(shadow_col) >= COLS) advance_row(attr);
        end
      end
      OP_CLEAR: begin
        // Keep attributes, blank characters, home the cursor.
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_cells[i][15:8], SPACE_CHAR};
        shadow_row = '0;
        shadow_col = '0;
      end
      OP_READ: begin
        if (int'(idx) < CELLS) rdata = shadow_cells[idx];
      end
      default: ;
    endcase
    pos            = int'(shadow_row) * COLS + int'(shadow_col);
    rep.row        = shadow_row;
    rep.column     = shadow_col;
    rep.position   = 11'(pos);
    rep.read_data  = rdata;
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one transaction, hold it until the block takes it, then record what it owes.
  // Start stays high into the next call unless a gap burst is drawn.
  task automatic send_op(input logic [1:0] op, input logic [7:0] ch,
                         input logic [7:0] attr, input logic [10:0] idx);
    cursor_report_t rep;
    start      <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    color      <= attr;
    cell_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    apply_console_op(op, ch, attr, idx, rep);
    cursor_report_q.push_back(rep);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] rand_printable();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255)); while (ch == NEWLINE_CHAR);
    return ch;
  endfunction

  function automatic logic [10:0] rand_index();
    return 11'($urandom_range(0, 2047));
  endfunction

  // Pick a read address: mostly just behind the cursor, some anywhere, a few past the end.
  function automatic logic [10:0] rand_read_index();
    int p;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      p = int'(shadow_row) * COLS + int'(shadow_col) - int'($urandom_range(0, 160));
      if (p < 0) p = 0;
      return 11'(p);
    end else if (pick < 9) begin
      return 11'($urandom_range(0, CELLS - 1));
    end
    return 11'($urandom_range(CELLS, 2047));
  endfunction

  // One random transaction: mostly printable text with newlines, reads behind the
  // cursor, and a little noise (null, unused opcode, clear).
  task automatic send_random_op();
    int pick;
    pick = $urandom_range(0, 999);
    if (pick < 560)
      send_op(OP_PUT, rand_printable(), 8'($urandom), rand_index());
    else if (pick < 710)
      send_op(OP_PUT, NEWLINE_CHAR, 8'($urandom), rand_index());
    else if (pick < 730)
      send_op(OP_PUT, NULL_CHAR, 8'($urandom), rand_index());
    else if (pick < 735)
      send_op(OP_CLEAR, 8'($urandom), 8'($urandom), rand_index());
    else if (pick < 765)
      send_op(OP_UNUSED, 8'($urandom), 8'($urandom), rand_index());
    else
      send_op(OP_READ, 8'($urandom), 8'($urandom), rand_read_index());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, null put, unused opcode, reads at both ends and past the store, newline and clear.
  task automatic test_directed_basics();
    send_op(OP_READ, 8'h00, 8'h00, 11'd0);        // store zero after reset
    send_op(OP_PUT, 8'hFF, 8'hFF, 11'h7FF);
    send_op(OP_PUT, 8'h01, 8'h00, 11'd0);
    send_op(OP_PUT, NULL_CHAR, 8'hA5, 11'd0);     // null changes nothing
    send_op(OP_UNUSED, 8'hFF, 8'hFF, 11'h7FF);    // unused opcode changes nothing
    send_op(OP_READ, 8'h00, 8'h00, 11'd0);
    send_op(OP_READ, 8'hFF, 8'hFF, 11'd1);
    send_op(OP_READ, 8'h00, 8'h00, 11'd2);
    send_op(OP_READ, 8'h00, 8'h00, 11'(CELLS - 1));
    send_op(OP_READ, 8'h00, 8'h00, 11'(CELLS));   // out of range reads zero
    send_op(OP_READ, 8'h00, 8'h00, 11'h7FF);
    send_op(OP_PUT, NEWLINE_CHAR, 8'h3C, 11'd0);
    send_op(OP_PUT, 8'h7F, 8'h80, 11'd0);
    send_op(OP_CLEAR, 8'h00, 8'h00, 11'd0);
    send_op(OP_READ, 8'h00, 8'h00, 11'd0);        // attribute kept, char blanked
    send_op(OP_READ, 8'h00, 8'h00, 11'd80);
    send_op(OP_READ, 8'h00, 8'h00, 11'd1000);
  endtask

  // Fill one row to the last column and check the wrap to the next row.
  task automatic test_line_wrap();
    send_op(OP_CLEAR, 8'($urandom), 8'($urandom), rand_index());
    for (int i = 0; i < COLS; i++) send_op(OP_PUT, rand_printable(), 8'($urandom), rand_index());
    send_op(OP_READ, 8'h00, 8'h00, 11'd0);
    send_op(OP_READ, 8'h00, 8'h00, 11'(COLS - 1));
    send_op(OP_READ, 8'h00, 8'h00, 11'(COLS));
  endtask

  // Walk down to the last row, scroll by wrap there, then by newline there.
  task automatic test_scroll_paths();
    for (int i = 0; i < ROWS; i++) send_op(OP_PUT, NEWLINE_CHAR, 8'($urandom), rand_index());
    for (int i = 0; i < COLS; i++) send_op(OP_PUT, rand_printable(), 8'($urandom), rand_index());
    send_op(OP_READ, 8'h00, 8'h00, 11'((ROWS - 1) * COLS));
    send_op(OP_READ, 8'h00, 8'h00, 11'((ROWS - 2) * COLS + COLS - 1));
    send_op(OP_PUT, 8'h41, 8'h1E, rand_index());
    send_op(OP_PUT, NEWLINE_CHAR, 8'hC3, rand_index());
    send_op(OP_READ, 8'h00, 8'h00, 11'((ROWS - 2) * COLS));
    send_op(OP_READ, 8'h00, 8'h00, 11'(CELLS - 1));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_random_op();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string what, input cursor_report_t want,
                              input cursor_report_t got);
    failure_count++;
    if (failure_count <= REPORT_LIMIT)
      $display("%s: expected row %0d col %0d pos %0d data %h, got row %0d col %0d pos %0d data %h",
               what, want.row, want.column, want.position, want.read_data,
               got.row, got.column, got.position, got.read_data);
  endtask

  // Sample on the edge that ends the strobe cycle; compare with the oldest owed report.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      seen_report = '{cursor_row, cursor_column, cursor_position, read_data};
      if (cursor_report_q.size() == 0) begin
        note_failure("unexpected result", '0, seen_report);
      end else begin
        owed_report = cursor_report_q.pop_front();
        if (seen_report.row !== owed_report.row ||
            seen_report.column !== owed_report.column ||
            seen_report.position !== owed_report.position ||
            seen_report.read_data !== owed_report.read_data)
          note_failure("mismatch", owed_report, seen_report);
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_text_console_cursor_scroll_unit: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    failure_count = 0;
    cycle_count   = 0;
    gaps_enabled  = 1'b1;
    shadow_row    = '0;
    shadow_col    = '0;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;

    rst        <= 1'b1;
    start      <= 1'b0;
    opcode     <= OP_PUT;
    char_code  <= NULL_CHAR;
    color      <= 8'h00;
    cell_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first transaction waits out the zero fill after reset on busy.
    test_directed_basics();
    test_line_wrap();
    test_scroll_paths();
    test_random_traffic(800);

    // Finish with no sender gaps so transactions go back to back.
    gaps_enabled = 1'b0;
    test_random_traffic(200);
    start <= 1'b0;

    // Drain owed reports, then watch a sweep's worth of cycles for strays.
    while (cursor_report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (cursor_report_q.size() != 0) failure_count++;
    if (failure_count == 0) begin
      $display("tb_text_console_cursor_scroll_unit: PASS");
    end else begin
      $display("tb_text_console_cursor_scroll_unit: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tcc_pkg.sv
rtl/core/tcc_ram.sv
rtl/core/tcc_walker.sv
rtl/core/text_console_cursor_scroll_unit.sv
sim/tb_text_console_cursor_scroll_unit.sv
